// ===== rtl/core/eicr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Edge interval capture ring: shared package
// Field widths, result kinds and the request record that travels from the
// front end through the request queue to the execution unit.
// ---------------------------------------------------------------------------
package eicr_pkg;

    localparam int TIME_W  = 32;
    localparam int WORDS_W = 7;
    localparam int AVAIL_W = 12;
    localparam int KIND_W  = 2;

    // Largest count that the available field can carry.
    localparam logic [AVAIL_W-1:0] AVAIL_MAX = 12'hFFF;

    // Command codes on the input side.
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result kinds on the output side.
    typedef enum logic [KIND_W-1:0] {
        KIND_EDGE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    // One classified request: an edge with its timestamp, or a read with its
    // word count already clamped to the burst limit.
    typedef struct packed {
        logic              is_read;
        logic [TIME_W-1:0] edge_time;
        logic [WORDS_W-1:0] want;
    } t_req;

endpackage : eicr_pkg
`default_nettype wire

// ===== rtl/core/eicr_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Edge interval capture ring: front end
// Accepts input requests, classifies them as edge or read, clamps the read
// length and holds the result in a register ahead of the request queue.
// ---------------------------------------------------------------------------
module eicr_front #(
    parameter int MAX_BURST = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire                                 i_command,
    input  wire  [eicr_pkg::TIME_W-1:0]         i_edge_time,
    input  wire  [eicr_pkg::WORDS_W-1:0]        i_read_words,
    output logic                                o_req_valid,
    output eicr_pkg::t_req                      o_req,
    input  wire                                 i_req_ready
);
    import eicr_pkg::*;

    localparam logic [WORDS_W-1:0] BURST_LIM = WORDS_W'(MAX_BURST);

    logic r_valid;
    t_req r_req;
    t_req n_req;

    // Classify the incoming request and clamp the read length.
    always_comb begin
        n_req.is_read   = (i_command == CMD_READ);
        n_req.edge_time = i_edge_time;
        n_req.want      = (i_read_words > BURST_LIM) ? BURST_LIM : i_read_words;
    end

    assign o_ready     = !r_valid || i_req_ready;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    // Holding register: refilled whenever it is empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_req <= n_req;
            end
        end
    end

endmodule : eicr_front
`default_nettype wire

// ===== rtl/core/eicr_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Edge interval capture ring: request queue
// Two-entry queue that decouples the front end from the execution unit.
// ---------------------------------------------------------------------------
module eicr_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push_valid,
    output logic            o_push_ready,
    input  eicr_pkg::t_req  i_push_req,
    output logic            o_pop_valid,
    input  wire             i_pop_ready,
    output eicr_pkg::t_req  o_pop_req
);
    import eicr_pkg::*;

    t_req       r_slot [2];
    logic       r_wr_idx;
    logic       r_rd_idx;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_req    = r_slot[r_rd_idx];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_idx] <= i_push_req;
        end
    end

    // Indexes and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule : eicr_queue
`default_nettype wire

// ===== rtl/core/eicr_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Edge interval capture ring: execution unit
// Owns the interval memory and the ring pointers. Records edges, drains read
// bursts word by word and drives the registered result stage.
// ---------------------------------------------------------------------------
module eicr_back #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_BURST  = 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_req_valid,
    input  eicr_pkg::t_req                  i_req,
    output logic                            o_req_ready,
    output logic                            o_valid,
    input  wire                             i_ready,
    output eicr_pkg::t_kind                 o_kind,
    output logic [eicr_pkg::TIME_W-1:0]     o_interval,
    output logic                            o_last,
    output logic [eicr_pkg::AVAIL_W-1:0]    o_available,
    output logic                            o_overflow
);
    import eicr_pkg::*;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int RUN_W   = (PTR_W + 1 > AVAIL_W) ? PTR_W + 1 : AVAIL_W;
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [RUN_W-1:0] RUN_DEPTH = RUN_W'(RING_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_RD_SEND
    } t_state;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    t_state              r_state;
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [TIME_W-1:0]   r_prev_time;
    logic                r_ovf;
    logic [BURST_W-1:0]  r_cnt;
    logic [AVAIL_W-1:0]  r_avail;
    logic [TIME_W-1:0]   r_rdata;
    logic [TIME_W-1:0]   r_mem [RING_DEPTH];

    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [TIME_W-1:0]   r_out_interval;
    logic                r_out_last;
    logic [AVAIL_W-1:0]  r_out_avail;
    logic                r_out_ovf;

    logic [RUN_W-1:0]    run;
    logic [AVAIL_W-1:0]  avail_now;
    logic [RUN_W-1:0]    want_ext;
    logic [RUN_W-1:0]    n_words;
    logic                out_free;
    logic                take;
    logic                edge_wr;
    logic [PTR_W-1:0]    wr_next;
    logic                wr_hits_rd;

    // Contiguous unread run from the read pointer, saturated for the port.
    always_comb begin
        if (r_rd_ptr < r_wr_ptr) begin
            run = RUN_W'(r_wr_ptr) - RUN_W'(r_rd_ptr);
        end else if (r_rd_ptr > r_wr_ptr) begin
            run = RUN_DEPTH - RUN_W'(r_rd_ptr);
        end else begin
            run = '0;
        end
        avail_now = (run > RUN_W'(AVAIL_MAX)) ? AVAIL_MAX : AVAIL_W'(run);
        want_ext  = RUN_W'(i_req.want);
        n_words   = (run < want_ext) ? run : want_ext;
    end

    assign out_free    = !r_out_valid || i_ready;
    assign o_req_ready = (r_state == S_IDLE) && out_free;
    assign take        = o_req_ready && i_req_valid;
    assign edge_wr     = take && !i_req.is_read;
    assign wr_next     = ptr_inc(r_wr_ptr);
    assign wr_hits_rd  = (wr_next == r_rd_ptr);

    // Interval memory: one write port for edges, one registered read port.
    always_ff @(posedge i_clk) begin
        if (edge_wr) begin
            r_mem[r_wr_ptr] <= i_req.edge_time - r_prev_time;
        end
        r_rdata <= r_mem[r_rd_ptr];
    end

    // Sequencer, ring pointers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_prev_time <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_out_valid    <= 1'b1;
                        r_out_interval <= '0;
                        r_out_last     <= 1'b1;
                        r_out_avail    <= avail_now;
                        r_out_ovf      <= r_ovf;
                        if (!i_req.is_read) begin
                            // Edge: store the interval, advance, drop oldest if full.
                            r_out_kind  <= KIND_EDGE;
                            r_prev_time <= i_req.edge_time;
                            r_wr_ptr    <= wr_next;
                            r_ovf       <= wr_hits_rd;
                            r_out_ovf   <= wr_hits_rd;
                            if (wr_hits_rd) begin
                                r_rd_ptr <= ptr_inc(r_rd_ptr);
                            end
                        end else if (n_words == '0) begin
                            r_out_kind <= KIND_EMPTY;
                        end else begin
                            // Read burst: the words follow from the memory port.
                            r_out_valid <= 1'b0;
                            r_cnt       <= BURST_W'(n_words);
                            r_avail     <= avail_now;
                            r_state     <= S_RD_WAIT;
                        end
                    end
                end
                S_RD_WAIT: begin
                    r_state <= S_RD_SEND;
                end
                S_RD_SEND: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_kind     <= KIND_DATA;
                        r_out_interval <= r_rdata;
                        r_out_last     <= (r_cnt == BURST_W'(1));
                        r_out_avail    <= r_avail;
                        r_out_ovf      <= r_ovf;
                        r_rd_ptr       <= ptr_inc(r_rd_ptr);
                        r_cnt          <= r_cnt - BURST_W'(1);
                        r_state        <= (r_cnt == BURST_W'(1)) ? S_IDLE : S_RD_WAIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_interval  = r_out_interval;
    assign o_last      = r_out_last;
    assign o_available = r_out_avail;
    assign o_overflow  = r_out_ovf;

    // A burst in progress always has words left to send.
    a_burst_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt != '0))
        else $error("burst active with zero words left");

    // Both pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= PTR_LAST) && (r_rd_ptr <= PTR_LAST))
        else $error("ring pointer out of range");

    // After an edge the ring is never empty.
    a_edge_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_wr |=> (r_rd_ptr != r_wr_ptr))
        else $error("ring empty right after an edge write");

    // The final word of a burst is marked and returns the unit to idle.
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_SEND && out_free && r_cnt == BURST_W'(1))
        |=> (r_state == S_IDLE && r_out_last && r_out_valid))
        else $error("burst end not marked");

endmodule : eicr_back
`default_nettype wire

// ===== rtl/core/edge_interval_capture_ring.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// Edge interval capture ring
// Stores edge-to-edge intervals in a ring buffer and returns them in bursts.
// ---------------------------------------------------------------------------
// A request is either an edge (tuser 0, timestamp in microseconds) or a read
// (tuser 1, word count). An edge stores the wrapped difference to the previous
// edge and returns one status result; a full ring drops its oldest entry and
// raises the overflow flag. A read returns up to MAX_BURST contiguous words,
// stopping at the write pointer or the end of the buffer, with tlast on the
// final one, or one empty result if nothing is read. The front end and a
// two-entry queue take one request per cycle until the queue fills. The
// execution unit handles an edge or an empty read in its idle state; a read
// burst enters a wait state and then a send state for each word, as the
// interval memory has a registered read port. The memory is not cleared;
// only entries written by edges are ever returned.
// ---------------------------------------------------------------------------
module edge_interval_capture_ring #(
    parameter int RING_DEPTH = 4096,
    parameter int MAX_BURST  = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] edge_time, [38:32] read_words, [39] zero
    input  wire  [39:0] i_s_axis_tdata,
    // [0] command
    input  wire         i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [31:0] interval, [43:32] available, [44] overflow, [47:45] zero
    output logic [47:0] o_m_axis_tdata,
    // [1:0] kind
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);
    import eicr_pkg::*;

    logic                front_valid;
    t_req                front_req;
    logic                q_push_ready;
    logic                q_pop_valid;
    t_req                q_pop_req;
    logic                back_ready;
    t_kind               out_kind;
    logic [TIME_W-1:0]   out_interval;
    logic [AVAIL_W-1:0]  out_avail;
    logic                out_ovf;

    // Request intake and classification.
    eicr_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_command    (i_s_axis_tuser),
        .i_edge_time  (i_s_axis_tdata[31:0]),
        .i_read_words (i_s_axis_tdata[38:32]),
        .o_req_valid  (front_valid),
        .o_req        (front_req),
        .i_req_ready  (q_push_ready)
    );

    // Queue between intake and execution.
    eicr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (q_push_ready),
        .i_push_req   (front_req),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (back_ready),
        .o_pop_req    (q_pop_req)
    );

    // Ring buffer and result generation.
    eicr_back #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_BURST  (MAX_BURST)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (q_pop_valid),
        .i_req       (q_pop_req),
        .o_req_ready (back_ready),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_kind      (out_kind),
        .o_interval  (out_interval),
        .o_last      (o_m_axis_tlast),
        .o_available (out_avail),
        .o_overflow  (out_ovf)
    );

    // Result packing.
    assign o_m_axis_tdata = {3'b000, out_ovf, out_avail, out_interval};
    assign o_m_axis_tuser = out_kind;

endmodule : edge_interval_capture_ring
`default_nettype wire

// ===== test/tb_edge_interval_capture_ring.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the edge interval capture ring
// Sends edge and read requests over the input stream and keeps its own copy
// of the ring, the pointers, the last timestamp and the overflow flag. Every
// returned result is compared field by field with the oldest predicted one.
// The sender works in bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_edge_interval_capture_ring;

    import eicr_pkg::*;

    localparam int RING_DEPTH  = 4096;
    localparam int MAX_BURST   = 64;
    localparam int QUIET_LIMIT = 5000;

    // One predicted result, in the order the block returns them.
    typedef struct {
        t_kind              kind;
        logic [TIME_W-1:0]  interval;
        logic               last;
        logic [AVAIL_W-1:0] available;
        logic               overflow;
    } t_interval_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [31:0] edge_time, [38:32] read_words, [39] zero
    logic [39:0] i_s_axis_tdata = '0;
    // [0] command
    logic        i_s_axis_tuser = CMD_EDGE;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [31:0] interval, [43:32] available, [44] overflow, [47:45] zero
    logic [47:0] o_m_axis_tdata;
    // [1:0] kind
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Predicted state of the ring.
    logic [TIME_W-1:0] ring_intervals [RING_DEPTH];
    int unsigned       ring_wr = 0;
    int unsigned       ring_rd = 0;
    logic [TIME_W-1:0] ring_last_stamp = '0;
    logic              ring_ovf = 1'b0;

    t_interval_result  pending_results [$];
    int unsigned       error_count = 0;

    // Sender and receiver pacing.
    int unsigned       tx_gap_max = 0;
    int unsigned       tx_burst_left = 0;
    int unsigned       rx_hold_req = 0;
    int unsigned       rx_hold_left = 0;
    int unsigned       rx_phase = 0;
    logic [15:0]       rx_pattern = '1;
    logic [TIME_W-1:0] stamp_cursor = '0;
    int unsigned       quiet_cycles = 0;

    edge_interval_capture_ring #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_BURST (MAX_BURST)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Contiguous unread entries starting at the read pointer.
    function automatic int unsigned ring_run_length();
        if (ring_rd < ring_wr) return ring_wr - ring_rd;
        if (ring_rd > ring_wr) return RING_DEPTH - ring_rd;
        return 0;
    endfunction

    // Apply one accepted request to the predicted ring and queue its results.
    task automatic predict_capture(input logic cmd, input logic [TIME_W-1:0] stamp,
                                   input logic [WORDS_W-1:0] words);
        t_interval_result res;
        int unsigned      avail;
        int unsigned      want;
        int unsigned      count;
        int unsigned      i;
        avail = ring_run_length();
        if (avail > AVAIL_MAX) avail = AVAIL_MAX;
        res.interval  = '0;
        res.last      = 1'b1;
        res.available = avail[AVAIL_W-1:0];
        if (cmd == CMD_EDGE) begin
            ring_intervals[ring_wr] = stamp - ring_last_stamp;
            ring_last_stamp = stamp;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
            // A full ring gives up its oldest entry.
            if (ring_wr == ring_rd) begin
                ring_rd = (ring_rd + 1) % RING_DEPTH;
                ring_ovf = 1'b1;
            end else begin
                ring_ovf = 1'b0;
            end
            res.kind     = KIND_EDGE;
            res.overflow = ring_ovf;
            pending_results.push_back(res);
        end else begin
            want  = (words > MAX_BURST) ? MAX_BURST : words;
            count = (avail < want) ? avail : want;
            res.overflow = ring_ovf;
            if (count == 0) begin
                res.kind = KIND_EMPTY;
                pending_results.push_back(res);
            end else begin
                for (i = 0; i < count; i++) begin
                    res.kind     = KIND_DATA;
                    res.interval = ring_intervals[(ring_rd + i) % RING_DEPTH];
                    res.last     = (i + 1 == count);
                    pending_results.push_back(res);
                end
                ring_rd = (ring_rd + count) % RING_DEPTH;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Offer one request and hold it until the block takes it. The valid stays
    // high on return so a following request can go out on the next cycle.
    task automatic send_request(input logic cmd, input logic [TIME_W-1:0] stamp,
                                input logic [WORDS_W-1:0] words);
        int unsigned gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 12);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(1, tx_gap_max);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {1'b0, words, stamp};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_capture(cmd, stamp, words);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Mostly small steps forward, with jumps, repeats and steps backward.
    function automatic logic [TIME_W-1:0] next_stamp();
        case ($urandom_range(0, 9))
            0: stamp_cursor = $urandom;
            1: stamp_cursor = stamp_cursor - $urandom_range(1, 1000);
            2: ;
            3: stamp_cursor = stamp_cursor + $urandom_range(1000, 1000000);
            default: stamp_cursor = stamp_cursor + $urandom_range(1, 2000);
        endcase
        return stamp_cursor;
    endfunction

    function automatic logic [WORDS_W-1:0] pick_read_words();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WORDS_W'(MAX_BURST);
            2, 3: return WORDS_W'($urandom_range(0, MAX_BURST));
            default: return WORDS_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Empty reads, wrapping intervals, zero-word reads and bursts cut short
    // at the write pointer.
    task automatic test_directed_cases();
        tx_gap_max = 3;
        send_request(CMD_READ, 32'h0000_0000, 7'd5);
        send_request(CMD_READ, 32'hFFFF_FFFF, 7'd0);
        send_request(CMD_EDGE, 32'h0000_0000, 7'd0);
        send_request(CMD_EDGE, 32'h0000_0064, 7'd64);
        send_request(CMD_EDGE, 32'hFFFF_FFFF, 7'd0);
        send_request(CMD_EDGE, 32'h0000_0005, 7'd0);
        send_request(CMD_EDGE, 32'h8000_0000, 7'd0);
        send_request(CMD_EDGE, 32'h8000_0000, 7'd0);
        send_request(CMD_READ, 32'h0000_0000, 7'd0);
        send_request(CMD_READ, 32'h0000_0000, 7'd1);
        send_request(CMD_READ, 32'h0000_0000, 7'd64);
        send_request(CMD_READ, 32'hFFFF_FFFF, 7'd64);
        send_request(CMD_EDGE, 32'hAAAA_AAAA, 7'd0);
        send_request(CMD_EDGE, 32'h5555_5555, 7'd0);
        send_request(CMD_EDGE, 32'h5555_5556, 7'd0);
        send_request(CMD_READ, 32'h0000_0000, 7'd2);
        send_request(CMD_READ, 32'h0000_0000, 7'd63);
        stamp_cursor = 32'h5555_5556;
        wait_results_drained();
    endtask

    // The receiver holds off while requests keep coming, so the block fills.
    task automatic test_output_backpressure();
        int unsigned i;
        tx_gap_max = 0;
        rx_hold_req = 400;
        for (i = 0; i < 24; i++) begin
            if (i % 3 == 2) send_request(CMD_READ, $urandom, 7'd64);
            else send_request(CMD_EDGE, next_stamp(), WORDS_W'($urandom_range(0, MAX_BURST)));
        end
        wait_results_drained();
    endtask

    // Fill part of the ring, then drain it with reads of at least the burst
    // limit until it is empty.
    task automatic test_clamped_reads();
        int unsigned i;
        tx_gap_max = 0;
        for (i = 0; i < 40; i++)
            send_request(CMD_EDGE, next_stamp(), WORDS_W'($urandom_range(0, MAX_BURST)));
        tx_gap_max = 4;
        send_request(CMD_READ, $urandom, 7'd127);
        send_request(CMD_READ, $urandom, 7'd65);
        do send_request(CMD_READ, $urandom, 7'd64); while (ring_rd != ring_wr);
        send_request(CMD_READ, $urandom, 7'd64);
        send_request(CMD_EDGE, next_stamp(), 7'd0);
        send_request(CMD_READ, $urandom, 7'd64);
        wait_results_drained();
    endtask

    // Mixed edges and reads with changing sender pacing and one full pause.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned i;
        for (i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: tx_gap_max = 0;
                    1: tx_gap_max = 3;
                    default: tx_gap_max = 12;
                endcase
            end
            if ($urandom_range(0, 99) < 62)
                send_request(CMD_EDGE, next_stamp(), WORDS_W'($urandom_range(0, MAX_BURST)));
            else
                send_request(CMD_READ, $urandom, pick_read_words());
            if (i == n_items / 2) wait_results_drained();
        end
        wait_results_drained();
    endtask

    // Receiver: long hold-offs on request, otherwise a rotating stall pattern.
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_pattern = '1;
                    1: rx_pattern = 16'($urandom);
                    default: rx_pattern = 16'($urandom | $urandom);
                endcase
            end
            i_m_axis_tready <= rx_pattern[rx_phase];
            rx_phase = (rx_phase + 1) % 16;
        end
    end

    // Compare each returned result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_interval_result oldest;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d data=%h last=%b",
                                          o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                oldest = pending_results.pop_front();
                if (o_m_axis_tuser !== oldest.kind ||
                    o_m_axis_tdata[31:0] !== oldest.interval ||
                    o_m_axis_tlast !== oldest.last ||
                    o_m_axis_tdata[43:32] !== oldest.available ||
                    o_m_axis_tdata[44] !== oldest.overflow)
                    report_mismatch($sformatf(
                        "got kind=%0d interval=%h last=%b avail=%0d ovf=%b, wanted %0d %h %b %0d %b",
                        o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tlast,
                        o_m_axis_tdata[43:32], o_m_axis_tdata[44], oldest.kind,
                        oldest.interval, oldest.last, oldest.available, oldest.overflow));
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_output_backpressure();
        test_clamped_reads();
        test_random_traffic(360);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
